### rtl/brat_pkg.sv
// Shared types and constants for the bus range address translator.
package brat_pkg;

   localparam int WORD_W  = 32;
   localparam int INDEX_W = 5;
   localparam int COUNT_W = 6;

   // Command codes carried on req_command
   localparam logic CMD_LOAD      = 1'b0;
   localparam logic CMD_TRANSLATE = 1'b1;

   // One table entry as held in the range memory
   typedef struct packed {
      logic [WORD_W-1:0] child_space;
      logic [WORD_W-1:0] child_base;
      logic [WORD_W-1:0] parent_space;
      logic [WORD_W-1:0] parent_base;
   } entry_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_PASS
   } state_type;

endpackage

### rtl/brat_ram.sv
// Generic single-write, single-read RAM with registered read data.
module brat_ram #(
   parameter int WIDTH = 128,
   parameter int DEPTH = 32
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write the addressed word
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Register the read word
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/brat_ctrl.sv
// Command sequencer: table loads, entry scan, result register.
module brat_ctrl #(
   parameter int TABLE_DEPTH = 32,
   parameter int AW          = 5,
   parameter int CW          = 6
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic                         req_command,
   input  logic [brat_pkg::INDEX_W-1:0] req_entry_index,
   input  logic [brat_pkg::WORD_W-1:0]  req_child_space,
   input  logic [brat_pkg::WORD_W-1:0]  req_child_base,
   input  logic [brat_pkg::WORD_W-1:0]  req_parent_space,
   input  logic [brat_pkg::WORD_W-1:0]  req_parent_base,
   input  logic [brat_pkg::WORD_W-1:0]  req_reg_space,
   input  logic [brat_pkg::WORD_W-1:0]  req_reg_addr,
   input  logic                         req_last_in_batch,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [brat_pkg::WORD_W-1:0]  rsp_out_space,
   output logic [brat_pkg::WORD_W-1:0]  rsp_out_addr,
   output logic                         rsp_found,
   output logic                         rsp_last_out,
   input  logic [CW-1:0]                limit,
   output logic                         ram_we,
   output logic [AW-1:0]                ram_waddr,
   output brat_pkg::entry_type          ram_wdata,
   output logic [AW-1:0]                ram_raddr,
   input  brat_pkg::entry_type          ram_rdata
);

   brat_pkg::state_type state_ff, state_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [CW-1:0] idx_next;
   logic [CW-1:0] limit_ff;
   logic [brat_pkg::WORD_W-1:0] space_ff, addr_ff;
   logic last_ff;

   logic rsp_valid_ff;
   logic [brat_pkg::WORD_W-1:0] rsp_space_ff, rsp_addr_ff;
   logic rsp_found_ff, rsp_last_ff;

   logic accept, out_free, hit, end_scan, finish, load_out;
   logic [brat_pkg::WORD_W-1:0] res_space, res_addr;
   logic res_found;

   assign req_stall = (state_ff != brat_pkg::ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // Compare the entry now on the read port
   assign idx_next = idx_ff + CW'(1);
   assign hit      = (ram_rdata.child_space == space_ff);
   assign end_scan = (idx_next == limit_ff);
   assign finish   = hit || end_scan;

   // Write a load word into the table when its slot exists
   assign ram_we = accept && (req_command == brat_pkg::CMD_LOAD) &&
                   (32'(req_entry_index) < 32'(TABLE_DEPTH));
   assign ram_waddr = AW'(req_entry_index);
   always_comb begin
      ram_wdata.child_space  = req_child_space;
      ram_wdata.child_base   = req_child_base;
      ram_wdata.parent_space = req_parent_space;
      ram_wdata.parent_base  = req_parent_base;
   end

   // Advance the state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= brat_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Sequence the scan and select the result
   always_comb begin
      state_in  = state_ff;
      idx_in    = idx_ff;
      load_out  = 1'b0;
      ram_raddr = AW'(0);
      res_space = space_ff;
      res_addr  = addr_ff;
      res_found = 1'b0;
      unique case (state_ff)
         brat_pkg::ST_IDLE: begin
            if (accept && (req_command == brat_pkg::CMD_TRANSLATE)) begin
               idx_in = '0;
               if (limit == '0) begin
                  state_in = brat_pkg::ST_PASS;
               end else begin
                  state_in = brat_pkg::ST_SCAN;
               end
            end
         end
         brat_pkg::ST_SCAN: begin
            if (hit) begin
               res_space = ram_rdata.parent_space;
               res_addr  = addr_ff - ram_rdata.child_base + ram_rdata.parent_base;
               res_found = 1'b1;
            end
            if (finish) begin
               // hold the entry on the read port until the result register frees
               ram_raddr = AW'(idx_ff);
               if (out_free) begin
                  load_out = 1'b1;
                  state_in = brat_pkg::ST_IDLE;
               end
            end else begin
               ram_raddr = AW'(idx_next);
               idx_in    = idx_next;
            end
         end
         brat_pkg::ST_PASS: begin
            if (out_free) begin
               load_out = 1'b1;
               state_in = brat_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = brat_pkg::ST_IDLE;
         end
      endcase
   end

   // Capture the translate word and scan position
   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      if (accept && (req_command == brat_pkg::CMD_TRANSLATE)) begin
         space_ff <= req_reg_space;
         addr_ff  <= req_reg_addr;
         last_ff  <= req_last_in_batch;
         limit_ff <= limit;
      end
   end

   // Hold the result word until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         rsp_space_ff <= res_space;
         rsp_addr_ff  <= res_addr;
         rsp_found_ff <= res_found;
         rsp_last_ff  <= last_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_space = rsp_space_ff;
   assign rsp_out_addr  = rsp_addr_ff;
   assign rsp_found     = rsp_found_ff;
   assign rsp_last_out  = rsp_last_ff;

   // The scan index never passes the last searched entry
   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == brat_pkg::ST_SCAN) |-> (idx_ff < limit_ff))
      else $error("scan index beyond search limit");

   // A new result never overwrites one that is still stalled
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      load_out |-> out_free)
      else $error("result register overwritten while stalled");

   // An empty table sends a translate straight to pass-through
   a_empty_pass: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_command == brat_pkg::CMD_TRANSLATE) && (limit == '0))
      |=> (state_ff == brat_pkg::ST_PASS))
      else $error("empty table did not pass through");

   // Table writes happen only between translations
   a_write_idle: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (state_ff == brat_pkg::ST_IDLE))
      else $error("table written during a scan");

   // A finished scan loads the result register and returns to idle together
   a_finish_idle: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == brat_pkg::ST_SCAN) && finish && out_free)
      |=> (state_ff == brat_pkg::ST_IDLE) && rsp_valid_ff)
      else $error("finished scan did not deliver a result");

endmodule

### rtl/bus_range_address_translator.sv
// Top level of the bus range address translator: count register, table RAM, sequencer.
//
// A load word (command 0) writes one table entry as it is accepted; slots at or beyond
// TABLE_DEPTH are dropped. A translate word (command 1) searches entries 0 up to
// min(range_count, TABLE_DEPTH)-1 for the first whose child space equals req_reg_space
// and returns parent space and reg_addr - child_base + parent_base (mod 2^32) with
// rsp_found set, or the register unchanged with rsp_found clear. A translate holds the
// input until its scan ends: the table is one RAM with a single registered read port
// that the sequencer walks one entry per cycle, waiting at a match or the search limit
// while the held result is stalled; an empty table skips the scan. The result waits in
// an output register, so the next word is taken while it is still stalled. Entries must
// be loaded before a translate can reach them. The user must write range_count through
// csr_wr_en/csr_wr_data only while no word is in flight; the block does not enforce it.
module bus_range_address_translator #(
   parameter int TABLE_DEPTH = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_wr_en,
   input  logic [brat_pkg::COUNT_W-1:0] csr_wr_data,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic                         req_command,
   input  logic [brat_pkg::INDEX_W-1:0] req_entry_index,
   input  logic [brat_pkg::WORD_W-1:0]  req_child_space,
   input  logic [brat_pkg::WORD_W-1:0]  req_child_base,
   input  logic [brat_pkg::WORD_W-1:0]  req_parent_space,
   input  logic [brat_pkg::WORD_W-1:0]  req_parent_base,
   input  logic [brat_pkg::WORD_W-1:0]  req_reg_space,
   input  logic [brat_pkg::WORD_W-1:0]  req_reg_addr,
   input  logic                         req_last_in_batch,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [brat_pkg::WORD_W-1:0]  rsp_out_space,
   output logic [brat_pkg::WORD_W-1:0]  rsp_out_addr,
   output logic                         rsp_found,
   output logic                         rsp_last_out
);

   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CW = $clog2(TABLE_DEPTH + 1);

   logic [brat_pkg::COUNT_W-1:0] range_count_ff;
   logic [CW-1:0] limit;

   logic ram_we;
   logic [AW-1:0] ram_waddr, ram_raddr;
   brat_pkg::entry_type ram_wdata, ram_rdata;

   // Hold the range count register
   always_ff @(posedge clock) begin
      if (reset) begin
         range_count_ff <= '0;
      end else if (csr_wr_en) begin
         range_count_ff <= csr_wr_data;
      end
   end

   // Clamp the search limit to the table depth
   always_comb begin
      if (7'(range_count_ff) > 7'(TABLE_DEPTH)) begin
         limit = CW'(TABLE_DEPTH);
      end else begin
         limit = CW'(range_count_ff);
      end
   end

   brat_ram #(
      .WIDTH ($bits(brat_pkg::entry_type)),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   brat_ctrl #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .AW          (AW),
      .CW          (CW)
   ) u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_command       (req_command),
      .req_entry_index   (req_entry_index),
      .req_child_space   (req_child_space),
      .req_child_base    (req_child_base),
      .req_parent_space  (req_parent_space),
      .req_parent_base   (req_parent_base),
      .req_reg_space     (req_reg_space),
      .req_reg_addr      (req_reg_addr),
      .req_last_in_batch (req_last_in_batch),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_out_space     (rsp_out_space),
      .rsp_out_addr      (rsp_out_addr),
      .rsp_found         (rsp_found),
      .rsp_last_out      (rsp_last_out),
      .limit             (limit),
      .ram_we            (ram_we),
      .ram_waddr         (ram_waddr),
      .ram_wdata         (ram_wdata),
      .ram_raddr         (ram_raddr),
      .ram_rdata         (ram_rdata)
   );

endmodule

### tb/tb_bus_range_address_translator.sv
// Self-checking testbench for the bus range address translator.
`timescale 1ns / 100ps

module tb_bus_range_address_translator;

   localparam int TABLE_DEPTH = 32;
   localparam int SETTLE_CYCLES = 40;
   localparam int HOLD_CYCLES = 300;
   localparam int PHASE_WORDS = 60;
   localparam int LOAD_PCT = 25;

   // One request word as offered on the req_ side
   typedef struct packed {
      logic                         command;
      logic [brat_pkg::INDEX_W-1:0] entry_index;
      brat_pkg::entry_type          entry;
      logic [brat_pkg::WORD_W-1:0]  reg_space;
      logic [brat_pkg::WORD_W-1:0]  reg_addr;
      logic                         last_in_batch;
   } request_word_type;

   // One translation word as returned on the rsp_ side
   typedef struct packed {
      logic [brat_pkg::WORD_W-1:0] out_space;
      logic [brat_pkg::WORD_W-1:0] out_addr;
      logic                        found;
      logic                        last_out;
   } translation_type;

   // Shadow range table, count register and queue of pending translations
   class translation_scoreboard;
      brat_pkg::entry_type          range_table[TABLE_DEPTH];
      logic [brat_pkg::COUNT_W-1:0] range_count;
      translation_type              pending_q[$];
      int                           mismatches;

      task report_mismatch(input string what);
         mismatches++;
         $display("mismatch: %s", what);
      endtask

      // Apply a load to the shadow table or queue the translation it predicts
      task note_word(input request_word_type w);
         int              limit;
         translation_type t;
         if (w.command == brat_pkg::CMD_LOAD) begin
            range_table[w.entry_index] = w.entry;
            return;
         end
         limit = (range_count > TABLE_DEPTH) ? TABLE_DEPTH : range_count;
         t = '{w.reg_space, w.reg_addr, 1'b0, w.last_in_batch};
         for (int i = 0; i < limit; i++) begin
            if (range_table[i].child_space == w.reg_space) begin
               t.out_space = range_table[i].parent_space;
               t.out_addr = w.reg_addr - range_table[i].child_base
                            + range_table[i].parent_base;
               t.found = 1'b1;
               break;
            end
         end
         pending_q.push_back(t);
      endtask

      // Compare one returned word with the oldest pending translation
      task check_result(input translation_type got);
         translation_type want;
         if (pending_q.size() == 0) begin
            report_mismatch($sformatf("unexpected word space=%h addr=%h found=%b",
                                      got.out_space, got.out_addr, got.found));
            return;
         end
         want = pending_q.pop_front();
         if (got.out_space !== want.out_space)
            report_mismatch($sformatf("out_space %h, want %h", got.out_space, want.out_space));
         if (got.out_addr !== want.out_addr)
            report_mismatch($sformatf("out_addr %h, want %h", got.out_addr, want.out_addr));
         if (got.found !== want.found)
            report_mismatch($sformatf("found %b, want %b", got.found, want.found));
         if (got.last_out !== want.last_out)
            report_mismatch($sformatf("last_out %b, want %b", got.last_out, want.last_out));
      endtask
   endclass

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         csr_wr_en = 1'b0;
   logic [brat_pkg::COUNT_W-1:0] csr_wr_data = '0;
   logic                         req_valid = 1'b0;
   logic                         req_stall;
   logic                         req_command = brat_pkg::CMD_LOAD;
   logic [brat_pkg::INDEX_W-1:0] req_entry_index = '0;
   logic [brat_pkg::WORD_W-1:0]  req_child_space = '0;
   logic [brat_pkg::WORD_W-1:0]  req_child_base = '0;
   logic [brat_pkg::WORD_W-1:0]  req_parent_space = '0;
   logic [brat_pkg::WORD_W-1:0]  req_parent_base = '0;
   logic [brat_pkg::WORD_W-1:0]  req_reg_space = '0;
   logic [brat_pkg::WORD_W-1:0]  req_reg_addr = '0;
   logic                         req_last_in_batch = 1'b0;
   logic                         rsp_valid;
   logic                         rsp_stall = 1'b0;
   logic [brat_pkg::WORD_W-1:0]  rsp_out_space;
   logic [brat_pkg::WORD_W-1:0]  rsp_out_addr;
   logic                         rsp_found;
   logic                         rsp_last_out;

   translation_scoreboard        sb = new();
   int                           send_idle_pct = 38;
   int                           recv_idle_pct = 46;
   int                           words_sent = 0;
   bit                           hold_request = 1'b0;
   logic [brat_pkg::WORD_W-1:0]  space_pool[8];

   bus_range_address_translator #(.TABLE_DEPTH(TABLE_DEPTH)) u_top (
      .clock             (clock),
      .reset             (reset),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_command       (req_command),
      .req_entry_index   (req_entry_index),
      .req_child_space   (req_child_space),
      .req_child_base    (req_child_base),
      .req_parent_space  (req_parent_space),
      .req_parent_base   (req_parent_base),
      .req_reg_space     (req_reg_space),
      .req_reg_addr      (req_reg_addr),
      .req_last_in_batch (req_last_in_batch),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_out_space     (rsp_out_space),
      .rsp_out_addr      (rsp_out_addr),
      .rsp_found         (rsp_found),
      .rsp_last_out      (rsp_last_out)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Favor spaces from a small pool so that translations hit
   function automatic logic [brat_pkg::WORD_W-1:0] pick_space();
      return ($urandom_range(99) < 80) ? space_pool[$urandom_range(7)]
                                       : brat_pkg::WORD_W'($urandom());
   endfunction

   // Build a load word; the translate fields carry noise
   function automatic request_word_type make_load(input int idx,
                                                  input logic [brat_pkg::WORD_W-1:0] cs,
                                                  input logic [brat_pkg::WORD_W-1:0] cb,
                                                  input logic [brat_pkg::WORD_W-1:0] ps,
                                                  input logic [brat_pkg::WORD_W-1:0] pb);
      request_word_type w;
      w.command = brat_pkg::CMD_LOAD;
      w.entry_index = brat_pkg::INDEX_W'(idx);
      w.entry = '{cs, cb, ps, pb};
      w.reg_space = $urandom();
      w.reg_addr = $urandom();
      w.last_in_batch = 1'($urandom_range(1));
      return w;
   endfunction

   // Build a translate word; the load fields carry noise
   function automatic request_word_type make_translate(
         input logic [brat_pkg::WORD_W-1:0] space,
         input logic [brat_pkg::WORD_W-1:0] addr,
         input logic last);
      request_word_type w;
      w.command = brat_pkg::CMD_TRANSLATE;
      w.entry_index = brat_pkg::INDEX_W'($urandom_range(TABLE_DEPTH - 1));
      w.entry = '{brat_pkg::WORD_W'($urandom()), brat_pkg::WORD_W'($urandom()),
                  brat_pkg::WORD_W'($urandom()), brat_pkg::WORD_W'($urandom())};
      w.reg_space = space;
      w.reg_addr = addr;
      w.last_in_batch = last;
      return w;
   endfunction

   // Offer one word after a random gap and hold it until taken
   task automatic send_word(input request_word_type w);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_command <= w.command;
      req_entry_index <= w.entry_index;
      req_child_space <= w.entry.child_space;
      req_child_base <= w.entry.child_base;
      req_parent_space <= w.entry.parent_space;
      req_parent_base <= w.entry.parent_base;
      req_reg_space <= w.reg_space;
      req_reg_addr <= w.reg_addr;
      req_last_in_batch <= w.last_in_batch;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      sb.note_word(w);
      words_sent++;
      // Swap the idle rates after a third of the run, drop them after two thirds
      if (words_sent == 170) begin
         send_idle_pct = 46;
         recv_idle_pct = 38;
      end else if (words_sent == 340) begin
         send_idle_pct = 0;
         recv_idle_pct = 0;
      end
   endtask

   // Drain every pending translation, let the block settle, then write the count
   task automatic set_range_count(input int value);
      req_valid <= 1'b0;
      while (sb.pending_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= brat_pkg::COUNT_W'(value);
      @(posedge clock);
      csr_wr_en <= 1'b0;
      sb.range_count = brat_pkg::COUNT_W'(value);
   endtask

   // Sample returned words and drive the stall, with one long hold on request
   initial begin
      int hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall)
            sb.check_result('{rsp_out_space, rsp_out_addr, rsp_found, rsp_last_out});
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_idle_pct);
         end
      end
   end

   initial begin
      #4_000_000;
      $display("status: fail");
      $finish;
   end

   initial begin
      int phase_counts[8];
      space_pool[0] = '0;
      space_pool[1] = '1;
      space_pool[2] = 32'h1234_5678;
      for (int i = 3; i < 8; i++) space_pool[i] = $urandom();
      phase_counts = '{32, 63, 1, 0, 33, $urandom_range(2, 31), 32, $urandom_range(0, 63)};

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Empty table: pass through at the address extremes
      set_range_count(0);
      send_word(make_translate('0, '0, 1'b0));
      send_word(make_translate('1, '1, 1'b1));

      // Load the first slots with extreme values and the top slot with random ones
      send_word(make_load(0, '0, '1, '1, '0));
      send_word(make_load(1, '1, '0, '0, '1));
      send_word(make_load(2, 32'h1234_5678, 32'h0000_1000, 32'h0000_000A, 32'h8000_0000));
      send_word(make_load(3, 32'h1234_5678, '0, 32'h0000_000B, '0));
      send_word(make_load(TABLE_DEPTH - 1, $urandom(), $urandom(), $urandom(), $urandom()));
      send_word(make_translate(32'h1234_5678, 32'h800, 1'b1));

      // Hits with wraparound, first match wins over a duplicate, and a miss
      set_range_count(4);
      send_word(make_translate('0, '0, 1'b0));
      send_word(make_translate('1, '1, 1'b1));
      send_word(make_translate(32'h1234_5678, 32'h800, 1'b0));
      send_word(make_translate(32'h0000_0005, $urandom(), 1'b1));
      send_word(make_translate('1, 32'h0000_0001, 1'b0));

      // Count stops short of the entry, then reaches it
      set_range_count(2);
      send_word(make_translate(32'h1234_5678, '1, 1'b1));
      set_range_count(3);
      send_word(make_translate(32'h1234_5678, '1, 1'b0));

      // Fill the rest of the table before any wider search
      for (int idx = 4; idx < TABLE_DEPTH - 1; idx++)
         send_word(make_load(idx, pick_space(), $urandom(), $urandom(), $urandom()));

      // Random mixes of loads and translations under several counts
      foreach (phase_counts[p]) begin
         set_range_count(phase_counts[p]);
         if (p == 1) hold_request = 1'b1;
         for (int n = 0; n < PHASE_WORDS; n++) begin
            if ($urandom_range(99) < LOAD_PCT)
               send_word(make_load($urandom_range(TABLE_DEPTH - 1), pick_space(),
                                   $urandom(), $urandom(), $urandom()));
            else
               send_word(make_translate(pick_space(), $urandom(),
                                        1'($urandom_range(1))));
         end
      end

      // Drain, then give stray words a chance to show up
      req_valid <= 1'b0;
      while (sb.pending_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending_q.size() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
